// ===== rtl/core/nms_pkg.sv =====
// Package for the nested medium stack: item types, the stack entry, cell
// control and chain types, and the float and id constants.
// No dependencies.
package nms_pkg;

  // Float bits of 1.0, used for the default outside index and empty transmittance.
  localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;
  // An object id of all ones marks an invalid object.
  localparam logic [31:0] BAD_ID = 32'hFFFF_FFFF;
  // Default stack depth.
  localparam int DEF_MAX_MEDIA = 8;

  // One surface hit.
  typedef struct packed {
    logic [31:0] geom_id;
    logic        from_front;
    logic        to_front;
    logic [31:0] albedo_red;
    logic [31:0] albedo_green;
    logic [31:0] albedo_blue;
    logic [31:0] ior_inside;
  } nms_in_t;

  // One result item.
  typedef struct packed {
    logic [31:0] outside_ior;
    logic [31:0] trans_red;
    logic [31:0] trans_green;
    logic [31:0] trans_blue;
    logic [3:0]  medium_count;
    logic        overflow;
    logic        exit_miss;
  } nms_out_t;

  // One stack entry as held by a cell.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] ior;
  } nms_entry_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic valid;   // cell holds a live entry
    logic load;    // take the new entry at this edge
    logic remove;  // a leaving hit is being applied at this edge
  } nms_ctrl_t;

  // Transmittance candidate handed down the chain.
  typedef struct packed {
    logic        hit;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
  } nms_pick_t;

endpackage

// ===== rtl/core/nms_cell.sv =====
// One cell of the medium stack: holds one entry, matches ids, shifts down
// on removal and picks the transmittance candidate. Depends on nms_pkg.
module nms_cell (
  input  logic                  clk,
  input  nms_pkg::nms_ctrl_t    ctrl,
  input  logic [31:0]           key,
  input  nms_pkg::nms_entry_t   new_entry,
  input  nms_pkg::nms_entry_t   upper_entry,
  input  logic                  found_in,
  output logic                  found_out,
  output logic                  hit,
  input  nms_pkg::nms_pick_t    pick_in,
  output nms_pkg::nms_pick_t    pick_out,
  output nms_pkg::nms_entry_t   entry
);
  import nms_pkg::*;

  // Id match on a live entry, and the first-match chain toward higher cells.
  assign hit       = ctrl.valid && (entry.id == key);
  assign found_out = found_in || hit;

  // Entry storage: append loads the new entry, removal pulls from above.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= new_entry;
    end else if (ctrl.remove && found_out && ctrl.valid) begin
      entry <= upper_entry;
    end
  end

  // The lowest live entry with a valid id wins the transmittance.
  always_comb begin
    if (ctrl.valid && (entry.id != BAD_ID)) begin
      pick_out.hit   = 1'b1;
      pick_out.red   = entry.red;
      pick_out.green = entry.green;
      pick_out.blue  = entry.blue;
    end else begin
      pick_out = pick_in;
    end
  end

endmodule

// ===== rtl/core/nested_medium_stack.sv =====
// Top level of the nested medium stack: handshakes, configuration register,
// entry count and the row of nms_cell instances. Depends on nms_pkg, nms_cell.
//
//   port group         direction  handshake           payload
//   in_valid/in_stall  input      accept: valid&!stall in_item  (nms_in_t)
//   out_valid/out_stall output    accept: valid&!stall out_item (nms_out_t)
//   cfg_write          input      write at edge       cfg_data (world_ior)
//
// The stack is searched and updated in the cells at the accept edge, and
// the finish state scans the updated row for the transmittance and loads
// the output register once it is free. The output register is free to
// wait on out_stall while the next item is accepted, unless a second
// result is ready before the first is taken. Reset empties the stack and
// restores world_ior to 1.0; entry contents are not cleared.
module nested_medium_stack #(
  parameter int MAX_MEDIA = nms_pkg::DEF_MAX_MEDIA
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  nms_pkg::nms_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output nms_pkg::nms_out_t out_item,
  input  logic              cfg_write,
  input  logic [31:0]       cfg_data
);
  import nms_pkg::*;

  localparam int CW = $clog2(MAX_MEDIA + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_MEDIA);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIN  = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [31:0]   world_ior;
  logic [31:0]   outside;
  logic          ovf;
  logic          miss;

  logic       accept;
  logic       entering;
  logic       leaving;
  logic       append_ok;
  logic       found_any;
  logic       out_load;
  logic [31:0] outside_now;

  nms_entry_t new_entry;
  nms_entry_t entries   [MAX_MEDIA];
  nms_ctrl_t  ctrl      [MAX_MEDIA];
  nms_pick_t  picks     [MAX_MEDIA];
  nms_pick_t  pick_top;
  logic       found     [MAX_MEDIA];
  logic       hits      [MAX_MEDIA];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign entering  = in_item.from_front && !in_item.to_front;
  assign leaving   = !in_item.from_front && in_item.to_front;
  assign append_ok = entering && (count != FULL);
  assign found_any = found[MAX_MEDIA-1];
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);

  assign new_entry.id    = in_item.geom_id;
  assign new_entry.red   = in_item.albedo_red;
  assign new_entry.green = in_item.albedo_green;
  assign new_entry.blue  = in_item.albedo_blue;
  assign new_entry.ior   = in_item.ior_inside;

  assign pick_top.hit   = 1'b0;
  assign pick_top.red   = FLOAT_ONE;
  assign pick_top.green = FLOAT_ONE;
  assign pick_top.blue  = FLOAT_ONE;

  // Row of cells; the match chain runs upward, the pick chain downward.
  for (genvar i = 0; i < MAX_MEDIA; i++) begin : g_cell
    assign ctrl[i].valid  = (CW'(i) < count);
    assign ctrl[i].load   = accept && append_ok && (count == CW'(i));
    assign ctrl[i].remove = accept && leaving;

    nms_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .key         (in_item.geom_id),
      .new_entry   (new_entry),
      .upper_entry ((i == MAX_MEDIA - 1) ? new_entry : entries[(i + 1) % MAX_MEDIA]),
      .found_in    ((i == 0) ? 1'b0 : found[(i + MAX_MEDIA - 1) % MAX_MEDIA]),
      .found_out   (found[i]),
      .hit         (hits[i]),
      .pick_in     ((i == MAX_MEDIA - 1) ? pick_top : picks[(i + 1) % MAX_MEDIA]),
      .pick_out    (picks[i]),
      .entry       (entries[i])
    );
  end

  // Outside index from the stack as it stands before the update.
  always_comb begin
    if (!in_item.from_front) begin
      priority if (!found_any || (count == CW'(1))) begin
        outside_now = world_ior;
      end else if (hits[0]) begin
        outside_now = entries[1].ior;
      end else begin
        outside_now = entries[0].ior;
      end
    end else begin
      outside_now = (count == '0) ? world_ior : entries[0].ior;
    end
  end

  // Sequencer: accept in idle, deliver the result in the finish cycle.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_FIN;
      ST_FIN:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      world_ior <= FLOAT_ONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        world_ior <= cfg_data;
      end
      if (accept) begin
        if (append_ok) begin
          count <= count + CW'(1);
        end else if (leaving && found_any) begin
          count <= count - CW'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-item flags and outside index held until the finish cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      outside <= outside_now;
      ovf     <= entering && (count == FULL);
      miss    <= leaving && !found_any;
    end
  end

  // Output register, loaded from the updated row.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.outside_ior  <= outside;
      out_item.trans_red    <= picks[0].red;
      out_item.trans_green  <= picks[0].green;
      out_item.trans_blue   <= picks[0].blue;
      out_item.medium_count <= 4'({4'b0000, count});
      out_item.overflow     <= ovf;
      out_item.exit_miss    <= miss;
    end
  end

  // The count never exceeds the depth of the row.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL) else $error("medium count beyond stack depth");

  // An accepted item always moves to the finish cycle.
  a_accept_fin: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_FIN)) else $error("accepted item not finishing");

  // A finish cycle with a free output register presents a result next.
  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid) else $error("result not presented");

  // A hit can not both overflow and miss.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.overflow && out_item.exit_miss))
    else $error("overflow and exit miss together");

endmodule
